>>> hw/rtl/wsdu_pkg.sv
package wsdu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [6:0] CODE_EXT16   = 7'd126;
  localparam logic [2:0] EXT16_LEFT   = 3'd1;
  localparam logic [2:0] EXT64_LEFT   = 3'd7;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] payload_length;
    logic [7:0]  plain_byte;
    logic        last_byte;
    logic        empty_frame;
    logic        length_error;
  } result_t;

endpackage

>>> hw/rtl/wsdu_in_if.sv
interface wsdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

>>> hw/rtl/wsdu_out_if.sv
interface wsdu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header_byte;
  logic [15:0] payload_length;
  logic [7:0]  plain_byte;
  logic        last_byte;
  logic        empty_frame;
  logic        length_error;

  modport source (output valid, header_byte, payload_length, plain_byte, last_byte,
                  empty_frame, length_error, input ready);
  modport sink (input valid, header_byte, payload_length, plain_byte, last_byte,
                empty_frame, length_error, output ready);
endinterface

>>> hw/rtl/websocket_frame_deframer_unmask_top.sv
// channel   dir  payload                                                  accept
// frames    in   rx_byte[8], frame_start[1]                               valid & ready
// results   out  header_byte[8], payload_length[16], plain_byte[8],       valid & ready
//                last_byte[1], empty_frame[1], length_error[1]
// One byte per cycle unless stalled; a result appears in the cycle after its byte.
// Parser state is updated on each input transfer; the result register holds the output.
// frames.ready drops only while a result waits and results.ready is low.
// rst is synchronous, active high, and returns the parser to waiting for a frame start.
module websocket_frame_deframer_unmask_top
  import wsdu_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  wsdu_in_if.sink   frames,
  wsdu_out_if.source results
);

  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_data;

  assign frames.ready = !out_valid || results.ready;
  assign take         = frames.valid && frames.ready;

  wsdu_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .rx_byte    (frames.rx_byte),
    .frame_start(frames.frame_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data <= res;
    end
  end

  assign results.valid          = out_valid;
  assign results.header_byte    = out_data.header_byte;
  assign results.payload_length = out_data.payload_length;
  assign results.plain_byte     = out_data.plain_byte;
  assign results.last_byte      = out_data.last_byte;
  assign results.empty_frame    = out_data.empty_frame;
  assign results.length_error   = out_data.length_error;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !frames.ready |-> out_valid && !results.ready)
    else $error("input stalled with room in result register");

endmodule

>>> hw/rtl/wsdu_parser.sv
module wsdu_parser
  import wsdu_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       res_valid,
  output result_t    res
);

  phase_t                 phase, phase_next;
  logic [7:0]             opcode_hold, opcode_hold_next;
  logic [LENGTH_BITS-1:0] length_hold, length_hold_next;
  logic                   length_overflow, length_overflow_next;
  logic [2:0]             ext_bytes_left, ext_bytes_left_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             key_bytes_seen, key_bytes_seen_next;
  logic [LENGTH_BITS-1:0] payload_count, payload_count_next;

  logic [6:0]             len_code;
  logic [1:0]             key_seen_inc;
  logic [LENGTH_BITS-1:0] count_inc;
  logic                   count_last;
  logic [7:0]             key_sel;

  assign len_code     = rx_byte[6:0];
  assign key_seen_inc = key_bytes_seen + 2'd1;
  assign count_inc    = payload_count + LENGTH_BITS'(1);
  assign count_last   = (count_inc == length_hold);

  always_comb begin
    unique case (payload_count[1:0])
      2'd0: key_sel = mask_key[31:24];
      2'd1: key_sel = mask_key[23:16];
      2'd2: key_sel = mask_key[15:8];
      2'd3: key_sel = mask_key[7:0];
      default: key_sel = mask_key[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    opcode_hold_next     = opcode_hold;
    length_hold_next     = length_hold;
    length_overflow_next = length_overflow;
    ext_bytes_left_next  = ext_bytes_left;
    mask_key_next        = mask_key;
    key_bytes_seen_next  = key_bytes_seen;
    payload_count_next   = payload_count;
    if (frame_start) begin
      phase_next           = PH_LEN;
      opcode_hold_next     = rx_byte;
      length_hold_next     = '0;
      length_overflow_next = 1'b0;
      ext_bytes_left_next  = '0;
      mask_key_next        = '0;
      key_bytes_seen_next  = '0;
      payload_count_next   = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_LEN: begin
          if (len_code < CODE_EXT16) begin
            length_hold_next = LENGTH_BITS'(len_code);
            phase_next       = PH_KEY;
          end else begin
            length_hold_next    = '0;
            ext_bytes_left_next = (len_code == CODE_EXT16) ? EXT16_LEFT : EXT64_LEFT;
            phase_next          = PH_EXT;
          end
        end
        PH_EXT: begin
          if (|length_hold[LENGTH_BITS-1 -: 8]) length_overflow_next = 1'b1;
          length_hold_next = (length_hold << 8) | LENGTH_BITS'(rx_byte);
          if (ext_bytes_left == 3'd0) phase_next = PH_KEY;
          else ext_bytes_left_next = ext_bytes_left - 3'd1;
        end
        PH_KEY: begin
          mask_key_next       = {mask_key[23:0], rx_byte};
          key_bytes_seen_next = key_seen_inc;
          if (key_seen_inc == 2'd0) begin
            payload_count_next = '0;
            if (length_overflow || length_hold == '0) phase_next = PH_IDLE;
            else phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          payload_count_next = count_inc;
          if (count_last) phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid          = 1'b0;
    res.header_byte    = opcode_hold;
    res.payload_length = '0;
    res.plain_byte     = '0;
    res.last_byte      = 1'b1;
    res.empty_frame    = 1'b0;
    res.length_error   = 1'b0;
    if (!frame_start) begin
      if (phase == PH_KEY && key_seen_inc == 2'd0) begin
        res_valid = 1'b1;
        if (length_overflow) res.length_error = 1'b1;
        else if (length_hold == '0) res.empty_frame = 1'b1;
        else res_valid = 1'b0;
      end else if (phase == PH_PAYLOAD) begin
        res_valid          = 1'b1;
        res.payload_length = 16'(length_hold);
        res.plain_byte     = rx_byte ^ key_sel;
        res.last_byte      = count_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      opcode_hold     <= '0;
      length_hold     <= '0;
      length_overflow <= 1'b0;
      ext_bytes_left  <= '0;
      mask_key        <= '0;
      key_bytes_seen  <= '0;
      payload_count   <= '0;
    end else if (take) begin
      phase           <= phase_next;
      opcode_hold     <= opcode_hold_next;
      length_hold     <= length_hold_next;
      length_overflow <= length_overflow_next;
      ext_bytes_left  <= ext_bytes_left_next;
      mask_key        <= mask_key_next;
      key_bytes_seen  <= key_bytes_seen_next;
      payload_count   <= payload_count_next;
    end
  end

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.last_byte |=> phase == PH_IDLE)
    else $error("frame did not end after last result");

  a_mid_stays_payload: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && !res.last_byte |=> phase == PH_PAYLOAD)
    else $error("payload phase left before last byte");

  a_marker_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.empty_frame && res.length_error)
      && ((res.empty_frame || res.length_error) ? res.last_byte : 1'b1))
    else $error("bad marker flags");

endmodule

>>> sim/tb_websocket_frame_deframer_unmask_top.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unmask_top;
  import wsdu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;
  localparam logic [6:0] CODE_EXT64 = 7'd127;

  logic clk;
  logic rst;

  wsdu_in_if frames();
  wsdu_out_if results();

  websocket_frame_deframer_unmask_top #(
    .LENGTH_BITS(16)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .frames(frames),
    .results(results)
  );

  // deframer state mirror
  phase_t phase_m = PH_IDLE;
  logic [7:0] opcode_m = '0;
  logic [15:0] length_m = '0;
  logic overflow_m = 1'b0;
  logic [2:0] ext_left_m = '0;
  logic [31:0] key_m = '0;
  logic [1:0] key_seen_m = '0;
  logic [15:0] pay_count_m = '0;

  result_t unmasked_q[$];
  logic [7:0] frame_bytes[$];

  int err_cnt = 0;
  int bytes_in = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int empty_seen = 0;
  int lerr_seen = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic deframe_byte(input logic [7:0] b, input logic s);
    result_t r;
    logic [6:0] code;
    int sh;
    code = b[6:0];
    r = '0;
    if (s) begin
      phase_m = PH_LEN;
      opcode_m = b;
      length_m = '0;
      overflow_m = 1'b0;
      ext_left_m = '0;
      key_m = '0;
      key_seen_m = '0;
      pay_count_m = '0;
    end else begin
      case (phase_m)
        PH_LEN: begin
          if (code < CODE_EXT16) begin
            length_m = {9'd0, code};
            phase_m = PH_KEY;
          end else begin
            length_m = '0;
            ext_left_m = (code == CODE_EXT16) ? EXT16_LEFT : EXT64_LEFT;
            phase_m = PH_EXT;
          end
        end
        PH_EXT: begin
          if (length_m[15:8] != 8'd0) overflow_m = 1'b1;
          length_m = {length_m[7:0], b};
          if (ext_left_m == 3'd0) phase_m = PH_KEY;
          else ext_left_m = ext_left_m - 3'd1;
        end
        PH_KEY: begin
          key_m = {key_m[23:0], b};
          key_seen_m = key_seen_m + 2'd1;
          if (key_seen_m == 2'd0) begin
            pay_count_m = '0;
            r.header_byte = opcode_m;
            r.last_byte = 1'b1;
            if (overflow_m) begin
              phase_m = PH_IDLE;
              r.length_error = 1'b1;
              unmasked_q.push_back(r);
            end else if (length_m == 16'd0) begin
              phase_m = PH_IDLE;
              r.empty_frame = 1'b1;
              unmasked_q.push_back(r);
            end else begin
              phase_m = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          sh = 8 * (3 - int'(pay_count_m[1:0]));
          r.plain_byte = b ^ key_m[sh +: 8];
          pay_count_m = pay_count_m + 16'd1;
          r.header_byte = opcode_m;
          r.payload_length = length_m;
          r.last_byte = (pay_count_m == length_m);
          unmasked_q.push_back(r);
          if (r.last_byte) phase_m = PH_IDLE;
        end
        default: phase_m = PH_IDLE;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && frames.valid && frames.ready) begin
      bytes_in++;
      deframe_byte(frames.rx_byte, frames.frame_start);
    end
  end

  function automatic void check_field(string fname, int unsigned e, int unsigned a);
    if (e !== a) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, e, a);
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && results.valid && results.ready) begin
      results_seen++;
      if (unmasked_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got hdr 0x%0h len %0d plain 0x%0h",
                 $time, results.header_byte, results.payload_length, results.plain_byte);
      end else begin
        exp_r = unmasked_q.pop_front();
        if (exp_r.empty_frame) empty_seen++;
        if (exp_r.length_error) lerr_seen++;
        check_field("header_byte", exp_r.header_byte, results.header_byte);
        check_field("payload_length", exp_r.payload_length, results.payload_length);
        check_field("plain_byte", exp_r.plain_byte, results.plain_byte);
        check_field("last_byte", exp_r.last_byte, results.last_byte);
        check_field("empty_frame", exp_r.empty_frame, results.empty_frame);
        check_field("length_error", exp_r.length_error, results.length_error);
      end
    end
  end

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if ((frames.valid && frames.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_websocket_frame_deframer_unmask_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < src_idle_pct) begin
      frames.valid <= 1'b0;
      @(posedge clk);
    end
    frames.valid <= 1'b1;
    frames.rx_byte <= b;
    frames.frame_start <= s;
    @(posedge clk);
    while (!frames.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic build_frame(input logic [7:0] hdr, input int form, input logic [63:0] flen,
                             input int unsigned npay);
    logic mb;
    mb = 1'($urandom_range(1));
    frame_bytes = {};
    frame_bytes.push_back(hdr);
    case (form)
      FORM_SHORT: frame_bytes.push_back({mb, flen[6:0]});
      FORM_EXT16: begin
        frame_bytes.push_back({mb, CODE_EXT16});
        frame_bytes.push_back(flen[15:8]);
        frame_bytes.push_back(flen[7:0]);
      end
      default: begin
        frame_bytes.push_back({mb, CODE_EXT64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(flen[8*i +: 8]);
      end
    endcase
    repeat (4) frame_bytes.push_back(8'($urandom));
    repeat (npay) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic send_frame_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(frame_bytes[i], i == 0);
  endtask

  task automatic test_directed;
    logic [7:0] ext_len[8];
    src_idle_pct = 0;
    snk_stall_pct = 0;
    ext_len = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    // header then a new start: dropped silently
    send_byte(8'h02, 1'b1);
    // zero length, mask bit set in the length byte
    send_byte(8'h89, 1'b1);
    send_byte(8'h80, 1'b0);
    repeat (4) send_byte(8'hff, 1'b0);
    // two payload bytes against key bytes ff and 00
    send_byte(8'hff, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    // past the payload: ignored
    send_byte(8'h00, 1'b0);
    // 64-bit length of 2^16: length error
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    foreach (ext_len[i]) send_byte(ext_len[i], 1'b0);
    repeat (4) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_max_length;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    // largest legal length in both extended forms, 24 payload bytes each
    build_frame(8'h82, FORM_EXT16, 64'd65535, 24);
    send_frame_bytes(frame_bytes.size());
    build_frame(8'h01, FORM_EXT64, 64'd65535, 24);
    send_frame_bytes(frame_bytes.size());
  endtask

  task automatic send_random_frame;
    int unsigned pick;
    int unsigned n;
    logic [63:0] flen;
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = $urandom_range(12);
      build_frame(8'($urandom), FORM_SHORT, 64'(n), n);
    end else if (pick < 45) begin
      n = $urandom_range(125);
      build_frame(8'($urandom), FORM_SHORT, 64'(n), n);
    end else if (pick < 60) begin
      n = $urandom_range(40);
      build_frame(8'($urandom), FORM_EXT16, 64'(n), n);
    end else if (pick < 64) begin
      n = $urandom_range(600, 126);
      build_frame(8'($urandom), FORM_EXT16, 64'(n), n);
    end else if (pick < 74) begin
      n = $urandom_range(300);
      build_frame(8'($urandom), FORM_EXT64, 64'(n), n);
    end else if (pick < 86) begin
      flen = {$urandom, $urandom};
      if ($urandom_range(1)) flen[63:17] = '0;
      flen[16 + $urandom_range(47)] = 1'b1;
      build_frame(8'($urandom), FORM_EXT64, flen, $urandom_range(6));
    end else begin
      n = $urandom_range(20);
      build_frame(8'($urandom), FORM_SHORT, 64'(n), n);
      send_frame_bytes($urandom_range(frame_bytes.size() - 1, 1));
      return;
    end
    send_frame_bytes(frame_bytes.size());
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int n_bytes);
    int start_cnt;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < n_bytes) send_random_frame();
  endtask

  task automatic finish_run;
    frames.valid <= 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    while (unmasked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (unmasked_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, unmasked_q.size());
    end
    $display("%0d bytes in, %0d results checked (%0d empty markers, %0d length errors)",
             bytes_in, results_seen, empty_seen, lerr_seen);
    $display("mixes: no gaps, sparse sender, stalling receiver, light gaps both; 65535 lengths");
    if (err_cnt == 0) begin
      $display("tb_websocket_frame_deframer_unmask_top: done, clean");
    end else begin
      $display("tb_websocket_frame_deframer_unmask_top: done, errors");
    end
    $finish;
  endtask

  initial begin
    rst <= 1'b1;
    frames.valid <= 1'b0;
    frames.rx_byte <= '0;
    frames.frame_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0, 420);
    test_random(82, 0, 420);
    test_random(0, 82, 420);
    test_random(6, 6, 420);
    test_max_length();
    finish_run();
  end

endmodule
